### sv/tmtw_pkg.sv
// Shared types and constants of the text-mode teletype writer.
package tmtw_pkg;

  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;
  localparam int LIN_OUT_W = 11;
  localparam int CELL_W    = CHAR_W + ATTR_W;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LINE_FEED = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    CMD_PRINT,
    CMD_NEWLINE,
    CMD_RETURN,
    CMD_BACKSPACE,
    CMD_TAB,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_BS,
    ST_SCROLL,
    ST_FILL
  } back_state_e;

endpackage

### sv/tmtw_if.sv
// Valid/ready channel interfaces for input items and result items.
interface tmtw_in_if import tmtw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source(output valid, op, char_code, cell_index, input ready);
  modport sink(input valid, op, char_code, cell_index, output ready);
endinterface

interface tmtw_out_if import tmtw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COL_OUT_W-1:0] cursor_col;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic [LIN_OUT_W-1:0] cursor_linear;
  logic [CHAR_W-1:0]    cell_char;
  logic [ATTR_W-1:0]    cell_attr;

  modport source(output valid, cursor_col, cursor_row, cursor_linear, cell_char, cell_attr,
                 input ready);
  modport sink(input valid, cursor_col, cursor_row, cursor_linear, cell_char, cell_attr,
               output ready);
endinterface

### sv/tmtw_front.sv
// Front end: accepts input beats, decodes them into commands and queues them.
module tmtw_front import tmtw_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_en_i,
  tmtw_in_if.sink       in_i,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  logic          cmd_ready_i
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            queue_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  cmd_t            dec_cmd;
  logic            push, pop;

  always_comb begin
    dec_cmd.ch   = in_i.char_code;
    dec_cmd.idx  = in_i.cell_index;
    dec_cmd.kind = CMD_PRINT;
    if (in_i.op == OP_READ) begin
      dec_cmd.kind = CMD_READ;
    end else begin
      case (in_i.char_code)
        CH_LINE_FEED: dec_cmd.kind = CMD_NEWLINE;
        CH_RETURN:    dec_cmd.kind = CMD_RETURN;
        CH_BACKSPACE: dec_cmd.kind = CMD_BACKSPACE;
        CH_TAB:       dec_cmd.kind = CMD_TAB;
        default:      dec_cmd.kind = CMD_PRINT;
      endcase
    end
  end

  assign in_i.ready  = accept_en_i && (count_q != CntW'(QUEUE_DEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= dec_cmd;
    end
  end

endmodule

### sv/tmtw_back.sv
// Back end: cursor, cell store, scroll sequencer and the result register.
module tmtw_back import tmtw_pkg::*; #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ATTR_W-1:0] attr_i,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_ready_o,
  output logic              clearing_o,
  tmtw_out_if.source        out_o
);

  localparam int CellCount = COLUMNS * ROWS;
  localparam int LinW      = $clog2(CellCount);
  localparam int ColW      = $clog2(COLUMNS);
  localparam int RowW      = $clog2(ROWS);
  localparam int PhW       = $clog2(TAB_WIDTH);

  logic [CELL_W-1:0] cell_mem [CellCount];

  back_state_e       state_q, state_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [LinW-1:0]   base_q, base_d;
  logic [PhW-1:0]    phase_q, phase_d;
  logic [LinW-1:0]   cnt_q, cnt_d;
  logic              cp_vld_q;
  logic [LinW-1:0]   cp_addr_q;
  logic [CELL_W-1:0] rdata_q;

  logic              out_valid_q;
  logic [COL_OUT_W-1:0] res_col_q;
  logic [ROW_OUT_W-1:0] res_row_q;
  logic [LIN_OUT_W-1:0] res_lin_q;
  logic [CHAR_W-1:0]    res_char_q;
  logic [ATTR_W-1:0]    res_attr_q;

  logic              mem_we;
  logic [LinW-1:0]   waddr, raddr, here;
  logic [CELL_W-1:0] wdata;
  logic              fin, newline;
  logic [CHAR_W-1:0] fin_char;
  logic [ATTR_W-1:0] fin_attr;
  logic [ColW:0]     col_inc, col_tab;
  logic [LinW-1:0]   lin_next;

  assign here    = base_q + LinW'(col_q);
  assign col_inc = {1'b0, col_q} + 1'b1;
  assign col_tab = {1'b0, col_q} + (ColW+1)'(TAB_WIDTH) - (ColW+1)'(phase_q);

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    base_d      = base_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    mem_we      = 1'b0;
    waddr       = here;
    wdata       = '0;
    raddr       = here;
    cmd_ready_o = 1'b0;
    fin         = 1'b0;
    fin_char    = '0;
    fin_attr    = '0;
    newline     = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = cnt_q;
        if (cnt_q == LinW'(CellCount - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = LinW'(cnt_q + 1'b1);
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_ready_o = 1'b1;
          case (cmd_i.kind)
            CMD_PRINT: begin
              mem_we = 1'b1;
              wdata  = {attr_i, cmd_i.ch};
              if (col_inc >= (ColW+1)'(COLUMNS)) begin
                newline = 1'b1;
              end else begin
                col_d   = ColW'(col_inc);
                phase_d = (phase_q == PhW'(TAB_WIDTH - 1)) ? '0 : PhW'(phase_q + 1'b1);
                fin     = 1'b1;
              end
            end
            CMD_NEWLINE: newline = 1'b1;
            CMD_RETURN: begin
              col_d   = '0;
              phase_d = '0;
              fin     = 1'b1;
            end
            CMD_BACKSPACE: begin
              if (col_q == '0) begin
                fin = 1'b1;
              end else begin
                state_d = ST_BS;
              end
            end
            CMD_TAB: begin
              if (col_tab >= (ColW+1)'(COLUMNS)) begin
                newline = 1'b1;
              end else begin
                col_d   = ColW'(col_tab);
                phase_d = '0;
                fin     = 1'b1;
              end
            end
            CMD_READ: begin
              if (32'(cmd_i.idx) < CellCount) begin
                raddr   = LinW'(cmd_i.idx);
                state_d = ST_READ;
              end else begin
                fin = 1'b1;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        fin      = 1'b1;
        fin_char = rdata_q[CHAR_W-1:0];
        fin_attr = rdata_q[CELL_W-1:CHAR_W];
        state_d  = ST_IDLE;
      end
      ST_BS: begin
        // The character survives; only the attribute byte is cleared.
        mem_we  = 1'b1;
        wdata   = {{ATTR_W{1'b0}}, rdata_q[CHAR_W-1:0]};
        col_d   = ColW'(col_q - 1'b1);
        phase_d = (phase_q == '0) ? PhW'(TAB_WIDTH - 1) : PhW'(phase_q - 1'b1);
        fin     = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCROLL: begin
        raddr = cnt_q;
        if (cnt_q == LinW'(CellCount - 1)) begin
          state_d = ST_FILL;
          cnt_d   = LinW'(CellCount - COLUMNS);
        end else begin
          cnt_d = LinW'(cnt_q + 1'b1);
        end
      end
      ST_FILL: begin
        // The last copy write still owns the port in the first fill cycle.
        if (!cp_vld_q) begin
          mem_we = 1'b1;
          waddr  = cnt_q;
          wdata  = {attr_i, {CHAR_W{1'b0}}};
          if (cnt_q == LinW'(CellCount - 1)) begin
            fin     = 1'b1;
            state_d = ST_IDLE;
          end else begin
            cnt_d = LinW'(cnt_q + 1'b1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (newline) begin
      col_d   = '0;
      phase_d = '0;
      if (row_q == RowW'(ROWS - 1)) begin
        state_d = ST_SCROLL;
        cnt_d   = LinW'(COLUMNS);
      end else begin
        row_d  = RowW'(row_q + 1'b1);
        base_d = LinW'(base_q + LinW'(COLUMNS));
        fin    = 1'b1;
      end
    end

    if (cp_vld_q) begin
      mem_we = 1'b1;
      waddr  = cp_addr_q;
      wdata  = rdata_q;
    end
  end

  assign lin_next = base_d + LinW'(col_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      phase_q     <= '0;
      cnt_q       <= '0;
      cp_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      row_q    <= row_d;
      base_q   <= base_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      cp_vld_q <= (state_q == ST_SCROLL);
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q <= LinW'(cnt_q - LinW'(COLUMNS));
    if (fin) begin
      res_col_q  <= COL_OUT_W'(col_d);
      res_row_q  <= ROW_OUT_W'(row_d);
      res_lin_q  <= LIN_OUT_W'(lin_next);
      res_char_q <= fin_char;
      res_attr_q <= fin_attr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[waddr] <= wdata;
    end
    rdata_q <= cell_mem[raddr];
  end

  assign clearing_o          = (state_q == ST_CLEAR);
  assign out_o.valid         = out_valid_q;
  assign out_o.cursor_col    = res_col_q;
  assign out_o.cursor_row    = res_row_q;
  assign out_o.cursor_linear = res_lin_q;
  assign out_o.cell_char     = res_char_q;
  assign out_o.cell_attr     = res_attr_q;

endmodule

### sv/text_mode_teletype_writer.sv
// Results: a printed character or cursor control finishes in the idle state; an in-range cell
// read or a backspace away from column zero first passes through a read or backspace state;
// a line feed or wrap on the last row runs a scroll, in which the cell store copies one cell
// per cycle and then fills the new last row. The back end takes a new command only once the
// last result is taken, and a 2-entry queue takes beats while the back end is busy. After
// reset the store is cleared, one cell per cycle, during which no input beat is taken.
module text_mode_teletype_writer import tmtw_pkg::*; #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_wdata_i,
  tmtw_in_if.sink           in_i,
  tmtw_out_if.source        out_o
);

  logic [ATTR_W-1:0] attr_q;
  logic              cmd_valid;
  logic              cmd_ready;
  cmd_t              cmd;
  logic              clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  tmtw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_en_i (!clearing),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  tmtw_back #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .attr_i      (attr_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .clearing_o  (clearing),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !out_o.valid)
    else $error("result presented during the store clearing pass");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (32'(out_o.cursor_row) < ROWS))
    else $error("cursor row beyond the last row");

  a_linear_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (COLUMNS <= 128 && ROWS <= 32 && out_o.valid) |->
      (32'(out_o.cursor_linear) ==
       (32'(out_o.cursor_row) * COLUMNS + 32'(out_o.cursor_col)) % 2048))
    else $error("linear cursor position disagrees with row and column");
`endif

endmodule
